// ----- rtl/core/cecf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the contrast-enforcing color fade.
package cecf_pkg;

  localparam int BISECT_STEPS   = 24;
  localparam int LUMA_FRAC_BITS = 16;

  localparam int FADE_W = BISECT_STEPS + 1;      // fade amount, 1.0 included
  localparam int LUT_W  = LUMA_FRAC_BITS + 1;    // linear value, 1.0 included
  localparam int LUMA_W = LUMA_FRAC_BITS + 14;   // weighted sum plus offset
  localparam int MIN_W  = 13;
  localparam int CMP_W  = LUMA_W + MIN_W;

  localparam logic [MIN_W-1:0]  MIN_RESET  = MIN_W'(768);
  localparam logic [LUMA_W-1:0] W_RED      = LUMA_W'(2126);
  localparam logic [LUMA_W-1:0] W_GREEN    = LUMA_W'(7152);
  localparam logic [LUMA_W-1:0] W_BLUE     = LUMA_W'(722);
  localparam logic [LUMA_W-1:0] LUMA_OFF   = LUMA_W'(64'd500 << LUMA_FRAC_BITS);
  localparam logic [LUMA_W-1:0] LUMA_HALF  = LUMA_W'(64'd5000 << LUMA_FRAC_BITS);
  localparam logic [FADE_W-1:0] FADE_ONE   = FADE_W'(64'd1 << BISECT_STEPS);

  typedef logic [LUT_W-1:0] lut_t [256];

  typedef struct packed {
    logic [7:0]        fr;
    logic [7:0]        fg;
    logic [7:0]        fb;
    logic              white;
    logic              adj;
    logic [LUMA_W-1:0] s_canvas;
    logic [FADE_W-1:0] lo;
    logic [FADE_W-1:0] hi;
  } cecf_item_t;

  function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
    mul_q31 = (a * b) >> 31;
  endfunction

  function automatic lut_t build_lut();
    lut_t t;
    logic [63:0] c;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] z;
    logic [63:0] cand;
    logic [63:0] z2;
    logic [63:0] z4;
    logic [63:0] z5;
    logic [63:0] y;
    for (int i = 0; i < 256; i++) begin
      c = 64'(i);
      if (i <= 10) begin
        t[i] = LUT_W'((((c * 64'd100) << LUMA_FRAC_BITS) + 64'd164730) / 64'd329460);
      end else begin
        x  = ((c * 64'd1000 + 64'd14025) << 31) / 64'd269025;
        x2 = mul_q31(x, x);
        z  = 64'd0;
        for (int b = 31; b >= 0; b--) begin
          cand = z | (64'd1 << b);
          z2   = mul_q31(cand, cand);
          z4   = mul_q31(z2, z2);
          z5   = mul_q31(z4, cand);
          if (cand <= (64'd1 << 31) && z5 <= x2) begin
            z = cand;
          end
        end
        y    = mul_q31(x2, z);
        t[i] = LUT_W'((y + (64'd1 << (30 - LUMA_FRAC_BITS))) >> (31 - LUMA_FRAC_BITS));
      end
    end
    return t;
  endfunction

  localparam lut_t LIN_LUT = build_lut();

  function automatic logic [LUMA_W-1:0] luma(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    logic [LUMA_W-1:0] lr;
    logic [LUMA_W-1:0] lg;
    logic [LUMA_W-1:0] lb;
    lr = LUMA_W'(LIN_LUT[r]);
    lg = LUMA_W'(LIN_LUT[g]);
    lb = LUMA_W'(LIN_LUT[b]);
    luma = lr * W_RED + lg * W_GREEN + lb * W_BLUE;
  endfunction

  // Cross-multiplied ratio test: (max + off) * 256 >= min * (min_luma + off).
  function automatic logic passes(input logic [LUMA_W-1:0] sa, input logic [LUMA_W-1:0] sb,
                                  input logic [MIN_W-1:0] min_q8);
    logic [LUMA_W-1:0] smax;
    logic [LUMA_W-1:0] smin;
    logic [CMP_W-1:0]  lhs;
    logic [CMP_W-1:0]  rhs;
    smax = (sa > sb) ? sa : sb;
    smin = (sa > sb) ? sb : sa;
    lhs  = CMP_W'(smax + LUMA_OFF) << 8;
    rhs  = CMP_W'(min_q8) * CMP_W'(smin + LUMA_OFF);
    passes = (lhs >= rhs);
  endfunction

  function automatic logic [7:0] fade_ch(input logic [7:0] from, input logic white,
                                         input logic [FADE_W-1:0] f);
    logic [7:0]        d;
    logic [FADE_W+7:0] p;
    logic [7:0]        q;
    d = white ? (8'd255 - from) : from;
    p = (FADE_W+8)'(d) * (FADE_W+8)'(f);
    q = p[BISECT_STEPS+7:BISECT_STEPS];
    fade_ch = white ? (from + q) : (from - q);
  endfunction

endpackage

// ----- rtl/core/cecf_front.sv -----
// Entry stages: luminance of both colors, initial ratio test and fade target.
module cecf_front import cecf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [MIN_W-1:0]  min_contrast,
  input  logic              v_in,
  input  logic [47:0]       data_in,
  output logic              v_out,
  output cecf_item_t        item_out
);

  logic              va_r;
  logic [47:0]       data_r;
  logic [LUMA_W-1:0] s_fg_r;
  logic [LUMA_W-1:0] s_cv_r;
  logic              vb_r;
  cecf_item_t        item_r;
  cecf_item_t        item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_in;
      s_fg_r <= luma(data_in[7:0], data_in[15:8], data_in[23:16]);
      s_cv_r <= luma(data_in[31:24], data_in[39:32], data_in[47:40]);
      item_r <= item_nxt;
    end
  end

  always_comb begin
    item_nxt.fr       = data_r[7:0];
    item_nxt.fg       = data_r[15:8];
    item_nxt.fb       = data_r[23:16];
    item_nxt.white    = !(s_cv_r > LUMA_HALF);
    item_nxt.adj      = !passes(s_fg_r, s_cv_r, min_contrast);
    item_nxt.s_canvas = s_cv_r;
    item_nxt.lo       = '0;
    item_nxt.hi       = FADE_ONE;
  end

  assign v_out    = vb_r;
  assign item_out = item_r;

endmodule

// ----- rtl/core/cecf_cell.sv -----
// One bisection step: fade by the midpoint, measure luminance, narrow the interval.
module cecf_cell import cecf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [MIN_W-1:0]  min_contrast,
  input  logic              v_in,
  input  cecf_item_t        item_in,
  output logic              v_out,
  output cecf_item_t        item_out
);

  logic              v1_r, v2_r, v3_r;
  cecf_item_t        it1_r, it2_r, it3_r;
  cecf_item_t        it3_nxt;
  logic [FADE_W-1:0] mid_nxt;
  logic [FADE_W-1:0] mid1_r, mid2_r;
  logic [7:0]        r1_r, g1_r, b1_r;
  logic [LUMA_W-1:0] s2_r;
  logic [FADE_W:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    sum     = {1'b0, item_in.lo} + {1'b0, item_in.hi};
    mid_nxt = sum[FADE_W:1];
    it3_nxt = it2_r;
    if (passes(s2_r, it2_r.s_canvas, min_contrast)) begin
      it3_nxt.hi = mid2_r;
    end else begin
      it3_nxt.lo = mid2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r  <= item_in;
      mid1_r <= mid_nxt;
      r1_r   <= fade_ch(item_in.fr, item_in.white, mid_nxt);
      g1_r   <= fade_ch(item_in.fg, item_in.white, mid_nxt);
      b1_r   <= fade_ch(item_in.fb, item_in.white, mid_nxt);
      it2_r  <= it1_r;
      mid2_r <= mid1_r;
      s2_r   <= luma(r1_r, g1_r, b1_r);
      it3_r  <= it3_nxt;
    end
  end

  assign v_out    = v3_r;
  assign item_out = it3_r;

endmodule

// ----- rtl/core/contrast_enforcing_color_fade_top.sv -----
// Top level: entry stages, chain of bisection cells and output register.
// Usage:
//   in_*   : one word per color pair; in_tdata = fg_red, fg_green, fg_blue,
//            canvas_red, canvas_green, canvas_blue from bit 0 up.
//   out_*  : one word per input; out_tdata = out_red, out_green, out_blue,
//            out_tuser = was_adjusted.
//   cfg_*  : writes min_contrast_q8 (Q5.8); always ready, reset value 3.0.
// Stages: two entry stages, three stages in each of the 24 bisection
// cells, and the output register. One word is accepted every cycle while
// in_tready is high; every word passes through all cells whether it needs
// a fade or not. Reset clears all valid flags and restores the minimum
// ratio; the pipeline then starts empty. When the receiver stalls, the
// output word holds and the pipeline keeps shifting until its last stage
// fills, after which in_tready drops until the output word is taken.
module contrast_enforcing_color_fade_top import cecf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // fg_red, fg_green, fg_blue, canvas_red,
                                        // canvas_green, canvas_blue
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // out_red, out_green, out_blue
  output logic              out_tuser,  // was_adjusted
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MIN_W-1:0]  cfg_data
);

  logic [MIN_W-1:0] min_r;
  logic             en;
  logic             out_load;
  logic             out_valid_r;
  logic [23:0]      out_data_r;
  logic             out_user_r;
  logic [23:0]      out_data_nxt;

  logic       v_chain [BISECT_STEPS+1];
  cecf_item_t it_chain [BISECT_STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RESET;
    end else if (cfg_valid) begin
      min_r <= cfg_data;
    end
  end

  // Shift while the last stage is empty or the output register can take it.
  assign out_load  = !out_valid_r || out_tready;
  assign en        = !v_chain[BISECT_STEPS] || out_load;
  assign in_tready = en;

  cecf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .min_contrast (min_r),
    .v_in         (in_tvalid),
    .data_in      (in_tdata),
    .v_out        (v_chain[0]),
    .item_out     (it_chain[0])
  );

  for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_cell
    cecf_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (en),
      .min_contrast (min_r),
      .v_in         (v_chain[i]),
      .item_in      (it_chain[i]),
      .v_out        (v_chain[i+1]),
      .item_out     (it_chain[i+1])
    );
  end

  always_comb begin
    if (it_chain[BISECT_STEPS].adj) begin
      out_data_nxt = {fade_ch(it_chain[BISECT_STEPS].fb, it_chain[BISECT_STEPS].white,
                              it_chain[BISECT_STEPS].hi),
                      fade_ch(it_chain[BISECT_STEPS].fg, it_chain[BISECT_STEPS].white,
                              it_chain[BISECT_STEPS].hi),
                      fade_ch(it_chain[BISECT_STEPS].fr, it_chain[BISECT_STEPS].white,
                              it_chain[BISECT_STEPS].hi)};
    end else begin
      out_data_nxt = {it_chain[BISECT_STEPS].fb, it_chain[BISECT_STEPS].fg,
                      it_chain[BISECT_STEPS].fr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= v_chain[BISECT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= it_chain[BISECT_STEPS].adj;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && v_chain[BISECT_STEPS]) |-> !in_tready)
    else $error("pipeline advanced into a stalled full output");
`endif

endmodule
